// File: rtl/core/t16cc_pkg.sv
// Shared types, register addresses and helper functions of the 16-bit timer.
`default_nettype none

package t16cc_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_ACK   = 2'd3
  } req_t;

  localparam logic [7:0] ADDR_CTRL_A  = 8'h80;
  localparam logic [7:0] ADDR_CTRL_B  = 8'h81;
  localparam logic [7:0] ADDR_CTRL_C  = 8'h82;
  localparam logic [7:0] ADDR_CNT_L   = 8'h84;
  localparam logic [7:0] ADDR_CNT_H   = 8'h85;
  localparam logic [7:0] ADDR_CAP_L   = 8'h86;
  localparam logic [7:0] ADDR_CAP_H   = 8'h87;
  localparam logic [7:0] ADDR_CMPA_L  = 8'h88;
  localparam logic [7:0] ADDR_CMPA_H  = 8'h89;
  localparam logic [7:0] ADDR_CMPB_L  = 8'h8A;
  localparam logic [7:0] ADDR_CMPB_H  = 8'h8B;
  localparam logic [7:0] ADDR_FLAGS   = 8'h36;
  localparam logic [7:0] ADDR_MASK    = 8'h6F;

  localparam logic [7:0] CTRL_A_MASK  = 8'hF3;
  localparam logic [7:0] CTRL_B_MASK  = 8'hDF;

  localparam logic [3:0] MODE_NORMAL  = 4'd0;
  localparam logic [3:0] MODE_CTC     = 4'd4;

  localparam logic [7:0] FLAG_OVF     = 8'h01;
  localparam logic [7:0] FLAG_CMPA    = 8'h02;
  localparam logic [7:0] FLAG_CAP     = 8'h20;

  localparam int unsigned PRESCALE_W  = 11;
  localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = 11'd1024;

  typedef struct packed {
    logic [1:0] ack_source;
    logic [7:0] wdata;
    logic [7:0] addr;
    req_t       req_type;
  } item_t;

  typedef struct packed {
    logic [3:0] irq;
    logic [7:0] rdata;
  } result_t;

  function automatic logic [7:0] line_bit(input logic [1:0] line);
    case (line)
      2'd0:    line_bit = 8'h01;
      2'd1:    line_bit = 8'h02;
      2'd2:    line_bit = 8'h04;
      default: line_bit = 8'h20;
    endcase
  endfunction

  function automatic logic [3:0] refresh_lines(input logic [3:0] pend,
                                               input logic [7:0] flags,
                                               input logic [7:0] mask);
    logic [3:0] res;
    res = pend;
    for (int i = 0; i < 4; i++) begin
      if ((mask & line_bit(2'(i))) != 8'h00) begin
        res[i] = ((flags & line_bit(2'(i))) != 8'h00);
      end
    end
    return res;
  endfunction

  function automatic logic [PRESCALE_W-1:0] divider(input logic [2:0] cs);
    case (cs)
      3'd1:    divider = 11'd1;
      3'd2:    divider = 11'd8;
      3'd3:    divider = 11'd64;
      3'd4:    divider = 11'd256;
      3'd5:    divider = 11'd1024;
      default: divider = 11'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/t16cc_core.sv
// Timer state registers and the combinational update for one word.
`default_nettype none

module t16cc_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire t16cc_pkg::item_t item,
  output t16cc_pkg::result_t    result
);

  logic [15:0] count_r, count_nxt;
  logic [15:0] cmpa_r, cmpa_nxt;
  logic [15:0] cmpb_r, cmpb_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic [7:0]  temp_r, temp_nxt;
  logic [7:0]  ctrl_a_r, ctrl_a_nxt;
  logic [7:0]  ctrl_b_r, ctrl_b_nxt;
  logic [7:0]  ctrl_c_r, ctrl_c_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [t16cc_pkg::PRESCALE_W-1:0] presc_r, presc_nxt;
  logic [3:0]  pend_r, pend_nxt;

  logic [t16cc_pkg::PRESCALE_W-1:0] div;
  logic [t16cc_pkg::PRESCALE_W-1:0] presc_dec;
  logic [3:0]  mode;
  logic [15:0] inc;
  logic [7:0]  newflags;
  logic        ctc_clr;
  logic [7:0]  rdata;

  assign div       = t16cc_pkg::divider(ctrl_b_r[2:0]);
  assign presc_dec = (presc_r != '0) ? presc_r - 1'b1 : presc_r;
  assign mode      = {ctrl_b_r[4:3], ctrl_a_r[1:0]};
  assign inc       = count_r + 16'd1;

  always_comb begin
    newflags = 8'h00;
    ctc_clr  = 1'b0;
    if (inc == 16'd0) begin
      newflags = t16cc_pkg::FLAG_OVF;
    end else if (mode == t16cc_pkg::MODE_CTC) begin
      if (inc == cmpa_r) begin
        newflags = newflags | t16cc_pkg::FLAG_CMPA;
        ctc_clr  = 1'b1;
      end
      if (inc == cap_r) begin
        newflags = newflags | t16cc_pkg::FLAG_CAP;
        ctc_clr  = 1'b1;
      end
    end
    if (mode != t16cc_pkg::MODE_NORMAL && mode != t16cc_pkg::MODE_CTC) begin
      newflags = 8'h00;
    end
  end

  always_comb begin
    case (item.addr)
      t16cc_pkg::ADDR_CTRL_A: rdata = ctrl_a_r;
      t16cc_pkg::ADDR_CTRL_B: rdata = ctrl_b_r;
      t16cc_pkg::ADDR_CTRL_C: rdata = ctrl_c_r;
      t16cc_pkg::ADDR_CNT_L:  rdata = count_r[7:0];
      t16cc_pkg::ADDR_CNT_H:  rdata = count_r[15:8];
      t16cc_pkg::ADDR_CAP_L:  rdata = cap_r[7:0];
      t16cc_pkg::ADDR_CAP_H:  rdata = cap_r[15:8];
      t16cc_pkg::ADDR_CMPA_L: rdata = cmpa_r[7:0];
      t16cc_pkg::ADDR_CMPA_H: rdata = cmpa_r[15:8];
      t16cc_pkg::ADDR_CMPB_L: rdata = cmpb_r[7:0];
      t16cc_pkg::ADDR_CMPB_H: rdata = cmpb_r[15:8];
      t16cc_pkg::ADDR_FLAGS:  rdata = flag_r;
      t16cc_pkg::ADDR_MASK:   rdata = mask_r;
      default:                rdata = 8'h00;
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    cmpa_nxt   = cmpa_r;
    cmpb_nxt   = cmpb_r;
    cap_nxt    = cap_r;
    temp_nxt   = temp_r;
    ctrl_a_nxt = ctrl_a_r;
    ctrl_b_nxt = ctrl_b_r;
    ctrl_c_nxt = ctrl_c_r;
    flag_nxt   = flag_r;
    mask_nxt   = mask_r;
    presc_nxt  = presc_r;
    pend_nxt   = pend_r;
    if (fire) begin
      case (item.req_type)
        t16cc_pkg::REQ_TICK: begin
          if (div != '0) begin
            if (presc_dec != '0) begin
              presc_nxt = presc_dec;
            end else begin
              presc_nxt = div;
              if (mode == t16cc_pkg::MODE_NORMAL || mode == t16cc_pkg::MODE_CTC) begin
                count_nxt = ctc_clr ? 16'd0 : inc;
              end
              if (newflags != 8'h00) begin
                flag_nxt = flag_r | newflags;
                pend_nxt = t16cc_pkg::refresh_lines(pend_r, flag_r | newflags, mask_r);
              end
            end
          end
        end
        t16cc_pkg::REQ_WRITE: begin
          case (item.addr)
            t16cc_pkg::ADDR_CTRL_A: ctrl_a_nxt = item.wdata & t16cc_pkg::CTRL_A_MASK;
            t16cc_pkg::ADDR_CTRL_B: ctrl_b_nxt = item.wdata & t16cc_pkg::CTRL_B_MASK;
            t16cc_pkg::ADDR_CTRL_C: ctrl_c_nxt = item.wdata;
            t16cc_pkg::ADDR_CNT_L:  count_nxt  = {temp_r, item.wdata};
            t16cc_pkg::ADDR_CAP_L:  cap_nxt    = {temp_r, item.wdata};
            t16cc_pkg::ADDR_CMPA_L: cmpa_nxt   = {temp_r, item.wdata};
            t16cc_pkg::ADDR_CMPB_L: cmpb_nxt   = {temp_r, item.wdata};
            t16cc_pkg::ADDR_CNT_H,
            t16cc_pkg::ADDR_CAP_H,
            t16cc_pkg::ADDR_CMPA_H,
            t16cc_pkg::ADDR_CMPB_H: temp_nxt   = item.wdata;
            t16cc_pkg::ADDR_FLAGS: begin
              flag_nxt = item.wdata;
              pend_nxt = t16cc_pkg::refresh_lines(pend_r, item.wdata, mask_r);
            end
            t16cc_pkg::ADDR_MASK: begin
              mask_nxt = item.wdata;
              pend_nxt = t16cc_pkg::refresh_lines(pend_r, flag_r, item.wdata);
            end
            default: ;
          endcase
        end
        t16cc_pkg::REQ_ACK: begin
          flag_nxt = flag_r & ~t16cc_pkg::line_bit(item.ack_source);
          pend_nxt = pend_r & ~(4'd1 << item.ack_source);
        end
        default: ;
      endcase
    end
  end

  assign result.rdata = (item.req_type == t16cc_pkg::REQ_READ) ? rdata : 8'h00;
  assign result.irq   = pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cmpa_r   <= '0;
      cmpb_r   <= '0;
      cap_r    <= '0;
      temp_r   <= '0;
      ctrl_a_r <= '0;
      ctrl_b_r <= '0;
      ctrl_c_r <= '0;
      flag_r   <= '0;
      mask_r   <= '0;
      presc_r  <= '0;
      pend_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      cmpa_r   <= cmpa_nxt;
      cmpb_r   <= cmpb_nxt;
      cap_r    <= cap_nxt;
      temp_r   <= temp_nxt;
      ctrl_a_r <= ctrl_a_nxt;
      ctrl_b_r <= ctrl_b_nxt;
      ctrl_c_r <= ctrl_c_nxt;
      flag_r   <= flag_nxt;
      mask_r   <= mask_nxt;
      presc_r  <= presc_nxt;
      pend_r   <= pend_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_presc_range: assert property (@(posedge clk) disable iff (!rst_n)
    presc_r <= t16cc_pkg::PRESCALE_MAX)
    else $error("prescaler holds more than the largest division");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(count_r) && $stable(flag_r) && $stable(pend_r))
    else $error("timer state moved without a word");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.req_type == t16cc_pkg::REQ_READ |=>
      $stable(count_r) && $stable(flag_r) && $stable(presc_r))
    else $error("a read changed the timer state");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.req_type == t16cc_pkg::REQ_ACK |=>
      pend_r[$past(item.ack_source)] == 1'b0)
    else $error("acknowledged line still pending");
`endif

endmodule

`default_nettype wire

// File: rtl/core/t16cc_out_stage.sv
// Result register that holds one finished word until the consumer takes it.
`default_nettype none

module t16cc_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire t16cc_pkg::result_t result,
  output logic                    can_load,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata
);

  logic               valid_r, valid_nxt;
  t16cc_pkg::result_t data_r;

  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'd0, data_r.irq, data_r.rdata};

endmodule

`default_nettype wire

// File: rtl/core/timer16_compare_capture_top.sv
// Top level of the 16-bit timer with compare and capture registers.
// The block takes one word in every cycle while the consumer takes results, and returns
// exactly one result word for each, held first in the input register and then in the result
// register. The whole update of the timer state for a word is combinational logic in the
// core, so a word may follow every cycle and the rate is one word per cycle for as long as
// the consumer takes results. Reads return the register byte before the word takes effect;
// the four interrupt lines show the pending state after it.
`default_nettype none

module timer16_compare_capture_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // addr[7:0], wdata[15:8], ack_source[17:16], zero fill
  input  wire logic [1:0]  in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // rdata[7:0], irq_overflow[8], irq_compare_a[9],
                                       // irq_compare_b[10], irq_capture[11], zero fill
);

  logic               s1_valid_r, s1_valid_nxt;
  t16cc_pkg::item_t   s1_item_r;
  t16cc_pkg::result_t result;
  logic               can_load;
  logic               fire;
  logic               in_fire;

  assign fire      = s1_valid_r && can_load;
  assign in_tready = !s1_valid_r || can_load;
  assign in_fire   = in_tvalid && in_tready;

  assign s1_valid_nxt = in_fire ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.req_type   <= t16cc_pkg::req_t'(in_tuser);
      s1_item_r.addr       <= in_tdata[7:0];
      s1_item_r.wdata      <= in_tdata[15:8];
      s1_item_r.ack_source <= in_tdata[17:16];
    end
  end

  t16cc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .result (result)
  );

  t16cc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: tb/timer16_tb_pkg.sv
`timescale 1ns / 1ps
// Testbench constants for the 16-bit timer that the block's own package does not provide.
package timer16_tb_pkg;

  localparam logic [2:0] CS_OFF      = 3'd0;
  localparam logic [2:0] CS_DIV1     = 3'd1;
  localparam logic [2:0] CS_DIV8     = 3'd2;
  localparam logic [2:0] CS_DIV64    = 3'd3;
  localparam logic [2:0] CS_DIV256   = 3'd4;
  localparam logic [2:0] CS_DIV1024  = 3'd5;
  localparam logic [2:0] CS_EXT_FALL = 3'd6;
  localparam logic [2:0] CS_EXT_RISE = 3'd7;

  localparam logic [1:0] WGM_B_NORMAL = 2'b00;
  localparam logic [1:0] WGM_B_CTC    = 2'b01;

  localparam logic [7:0] FLAG_CMPB = 8'h04;

endpackage

// File: tb/timer16_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 16-bit timer: predicts every result word and compares it with the output.
module timer16_checker
  import t16cc_pkg::*;
  import timer16_tb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  output int unsigned      mismatch_count,
  output int unsigned      results_due
);

  logic [15:0] tcnt, ocr_a, ocr_b, icr;
  logic [7:0]  hb_latch, ctl_a, ctl_b, ctl_c, flags, irq_mask;
  logic [10:0] ps_left;
  logic [3:0]  irq_pend;
  result_t     expected_q[$];
  result_t     want, got, predicted;

  function automatic logic [7:0] line_flag(input logic [1:0] line);
    case (line)
      2'd0:    return FLAG_OVF;
      2'd1:    return FLAG_CMPA;
      2'd2:    return FLAG_CMPB;
      default: return FLAG_CAP;
    endcase
  endfunction

  // Only lines whose mask bit is set follow their flag; the others hold.
  task automatic sync_irq_lines();
    for (int i = 0; i < 4; i++) begin
      if ((irq_mask & line_flag(2'(i))) != 8'h00) begin
        irq_pend[i] = ((flags & line_flag(2'(i))) != 8'h00);
      end
    end
  endtask

  task automatic advance_timer(input req_t kind, input logic [7:0] word_addr,
                               input logic [7:0] byte_in, input logic [1:0] src,
                               output result_t res);
    logic [10:0] div;
    logic [3:0]  mode;
    logic [7:0]  raised;
    logic [7:0]  rd;
    rd = 8'h00;
    case (kind)
      REQ_TICK: begin
        case (ctl_b[2:0])
          CS_DIV1:    div = 11'd1;
          CS_DIV8:    div = 11'd8;
          CS_DIV64:   div = 11'd64;
          CS_DIV256:  div = 11'd256;
          CS_DIV1024: div = 11'd1024;
          default:    div = 11'd0;
        endcase
        if (div != 11'd0) begin
          if (ps_left != 11'd0) ps_left = ps_left - 11'd1;
          if (ps_left == 11'd0) begin
            ps_left = div;
            mode = {ctl_b[4:3], ctl_a[1:0]};
            raised = 8'h00;
            if (mode == MODE_NORMAL || mode == MODE_CTC) begin
              tcnt = tcnt + 16'd1;
              if (tcnt == 16'h0000) begin
                raised = FLAG_OVF;
              end else if (mode == MODE_CTC) begin
                if (tcnt == ocr_a) raised = raised | FLAG_CMPA;
                if (tcnt == icr) raised = raised | FLAG_CAP;
                if (raised != 8'h00) tcnt = 16'h0000;
              end
            end
            if (raised != 8'h00) begin
              flags = flags | raised;
              sync_irq_lines();
            end
          end
        end
      end
      REQ_WRITE: begin
        case (word_addr)
          ADDR_CTRL_A: ctl_a = byte_in & CTRL_A_MASK;
          ADDR_CTRL_B: ctl_b = byte_in & CTRL_B_MASK;
          ADDR_CTRL_C: ctl_c = byte_in;
          ADDR_CNT_L:  tcnt = {hb_latch, byte_in};
          ADDR_CAP_L:  icr = {hb_latch, byte_in};
          ADDR_CMPA_L: ocr_a = {hb_latch, byte_in};
          ADDR_CMPB_L: ocr_b = {hb_latch, byte_in};
          ADDR_CNT_H, ADDR_CAP_H, ADDR_CMPA_H, ADDR_CMPB_H: hb_latch = byte_in;
          ADDR_FLAGS: begin
            flags = byte_in;
            sync_irq_lines();
          end
          ADDR_MASK: begin
            irq_mask = byte_in;
            sync_irq_lines();
          end
          default: ;
        endcase
      end
      REQ_READ: begin
        case (word_addr)
          ADDR_CTRL_A: rd = ctl_a;
          ADDR_CTRL_B: rd = ctl_b;
          ADDR_CTRL_C: rd = ctl_c;
          ADDR_CNT_L:  rd = tcnt[7:0];
          ADDR_CNT_H:  rd = tcnt[15:8];
          ADDR_CAP_L:  rd = icr[7:0];
          ADDR_CAP_H:  rd = icr[15:8];
          ADDR_CMPA_L: rd = ocr_a[7:0];
          ADDR_CMPA_H: rd = ocr_a[15:8];
          ADDR_CMPB_L: rd = ocr_b[7:0];
          ADDR_CMPB_H: rd = ocr_b[15:8];
          ADDR_FLAGS:  rd = flags;
          ADDR_MASK:   rd = irq_mask;
          default:     rd = 8'h00;
        endcase
      end
      default: begin
        flags = flags & ~line_flag(src);
        irq_pend[src] = 1'b0;
      end
    endcase
    res.rdata = rd;
    res.irq = irq_pend;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
    $display("%0t: mismatch in %s, got %0h, expected %0h", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tcnt = 16'h0000;
      ocr_a = 16'h0000;
      ocr_b = 16'h0000;
      icr = 16'h0000;
      hb_latch = 8'h00;
      ctl_a = 8'h00;
      ctl_b = 8'h00;
      ctl_c = 8'h00;
      flags = 8'h00;
      irq_mask = 8'h00;
      ps_left = 11'd0;
      irq_pend = 4'h0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[11:0]);
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing expected", got.rdata, 8'h00);
        end else begin
          want = expected_q.pop_front();
          if (got.rdata !== want.rdata) report_mismatch("rdata", got.rdata, want.rdata);
          for (int i = 0; i < 4; i++) begin
            if (got.irq[i] !== want.irq[i]) begin
              report_mismatch($sformatf("interrupt line %0d", i), 8'(got.irq[i]),
                              8'(want.irq[i]));
            end
          end
          if (out_tdata[15:12] !== 4'h0) report_mismatch("zero fill", 8'(out_tdata[15:12]), 8'h00);
        end
      end
      if (in_tvalid && in_tready) begin
        advance_timer(req_t'(in_tuser), in_tdata[7:0], in_tdata[15:8], in_tdata[17:16],
                      predicted);
        expected_q.push_back(predicted);
      end
    end
    results_due = expected_q.size();
  end

endmodule

// File: tb/tb_timer16_compare_capture_top.sv
`timescale 1ns / 1ps
// Testbench top for the 16-bit timer: drives request words, throttles results, gives the verdict.
module tb_timer16_compare_capture_top;
  import t16cc_pkg::*;
  import timer16_tb_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = 24'h000000;
  logic [1:0]  in_tuser = 2'b00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  int unsigned mismatch_count;
  int unsigned results_due;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  timer16_compare_capture_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  timer16_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The ready line is sampled at the falling edge, where it is stable.
  task automatic send_word(input req_t kind, input logic [7:0] word_addr,
                           input logic [7:0] byte_in, input logic [1:0] src);
    logic ready_seen;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {6'b000000, src, byte_in, word_addr};
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    words_sent++;
  endtask

  task automatic tick();
    send_word(REQ_TICK, 8'($urandom), 8'($urandom), 2'($urandom));
  endtask

  task automatic write_reg(input logic [7:0] word_addr, input logic [7:0] byte_in);
    send_word(REQ_WRITE, word_addr, byte_in, 2'($urandom));
  endtask

  task automatic read_reg(input logic [7:0] word_addr);
    send_word(REQ_READ, word_addr, 8'($urandom), 2'($urandom));
  endtask

  task automatic ack_line(input logic [1:0] src);
    send_word(REQ_ACK, 8'($urandom), 8'($urandom), src);
  endtask

  task automatic write16(input logic [7:0] low_addr, input logic [15:0] val);
    write_reg(low_addr + 8'd1, val[15:8]);
    write_reg(low_addr, val[7:0]);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Most of each phase configures the timer and then ticks it; the rest is random words, mostly at register addresses.
  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned n_words);
    int unsigned target;
    int unsigned pick;
    logic [2:0]  cs;
    logic [1:0]  wgm;
    logic [7:0]  noise_addr;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = words_sent + n_words;
    while (words_sent < target) begin
      if ($urandom_range(99, 0) < 65) begin
        if ($urandom_range(3, 0) != 0) write_reg(ADDR_MASK, 8'($urandom));
        if ($urandom_range(4, 0) == 0) write_reg(ADDR_CTRL_A, 8'($urandom));
        else write_reg(ADDR_CTRL_A, {6'($urandom), 2'b00});
        pick = $urandom_range(19, 0);
        if (pick < 10) cs = CS_DIV1;
        else if (pick < 15) cs = CS_DIV8;
        else if (pick < 17) cs = CS_DIV64;
        else if (pick == 17) cs = CS_DIV256;
        else if (pick == 18) cs = CS_DIV1024;
        else cs = 3'($urandom);
        pick = $urandom_range(9, 0);
        if (pick < 4) wgm = WGM_B_NORMAL;
        else if (pick < 8) wgm = WGM_B_CTC;
        else wgm = 2'($urandom);
        write_reg(ADDR_CTRL_B, {3'($urandom), wgm, cs});
        if ($urandom_range(1, 0) != 0) begin
          write16(ADDR_CMPA_L, ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(24, 1)));
        end
        if ($urandom_range(1, 0) != 0) begin
          write16(ADDR_CAP_L, ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(24, 1)));
        end
        if ($urandom_range(3, 0) == 0) write16(ADDR_CMPB_L, 16'($urandom));
        pick = $urandom_range(2, 0);
        if (pick == 0) write16(ADDR_CNT_L, 16'hFFF0 | 16'($urandom_range(15, 0)));
        else if (pick == 1) write16(ADDR_CNT_L, 16'($urandom_range(8, 0)));
        repeat ($urandom_range(40, 4)) tick();
        repeat ($urandom_range(4, 1)) read_reg(ADDR_CTRL_A + 8'($urandom_range(11, 0)));
        read_reg(ADDR_FLAGS);
        if ($urandom_range(1, 0) != 0) ack_line(2'($urandom));
        if ($urandom_range(5, 0) == 0) write_reg(ADDR_FLAGS, 8'($urandom));
      end else begin
        pick = $urandom_range(3, 0);
        if (pick == 0) noise_addr = 8'($urandom);
        else if (pick == 1) noise_addr = $urandom_range(1, 0) ? ADDR_FLAGS : ADDR_MASK;
        else noise_addr = ADDR_CTRL_A + 8'($urandom_range(11, 0));
        send_word(req_t'($urandom_range(3, 0)), noise_addr, 8'($urandom), 2'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    read_reg(ADDR_CTRL_B);
    tick();
    write_reg(ADDR_MASK, 8'hFF);
    write16(ADDR_CNT_L, 16'hFFFF);
    write_reg(ADDR_CTRL_B, {3'b000, WGM_B_NORMAL, CS_DIV1});
    tick();
    read_reg(ADDR_FLAGS);
    ack_line(2'd0);
    write16(ADDR_CMPA_L, 16'h0002);
    write_reg(ADDR_CAP_L, 8'h02);
    write_reg(ADDR_CTRL_B, {3'b000, WGM_B_CTC, CS_DIV1});
    tick();
    tick();
    write16(ADDR_CNT_L, 16'hFFFF);
    tick();
    write_reg(ADDR_FLAGS, FLAG_CMPB);
    ack_line(2'd1);
    ack_line(2'd2);
    ack_line(2'd3);
    write_reg(8'h83, 8'hFF);
    read_reg(8'h83);
    write_reg(ADDR_CTRL_A, 8'hFF);
    read_reg(ADDR_CTRL_A);
    write_reg(ADDR_CTRL_B, 8'hFF);
    tick();
    write_reg(ADDR_CTRL_B, {3'b000, WGM_B_NORMAL, CS_EXT_FALL});
    tick();
    write_reg(ADDR_CTRL_B, {3'b000, WGM_B_NORMAL, CS_DIV1024});
    tick();
    drain_results();

    random_phase(0, 0, 100);
    drain_results();
    random_phase(75, 0, 90);
    drain_results();
    random_phase(0, 75, 90);
    drain_results();
    random_phase(16, 16, 90);
    drain_results();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/t16cc_pkg.sv
rtl/core/t16cc_core.sv
rtl/core/t16cc_out_stage.sv
rtl/core/timer16_compare_capture_top.sv
tb/timer16_tb_pkg.sv
tb/timer16_checker.sv
tb/tb_timer16_compare_capture_top.sv
